// ===== design/wmmd_pkg.sv =====
// Shared constants, register indexes and the stage control type for the
// waveform min/max decimator. No dependencies.
package wmmd_pkg;

   localparam int MAX_CHANNELS   = 8;
   localparam int SAMPLE_BITS    = 24;
   localparam int COUNT_BITS     = 24;

   localparam int FIELD_CHANNELS = 8;
   localparam int SPB_W          = 24;
   localparam int NCH_W          = 4;
   localparam int CSR_W          = 24;
   localparam int CSR_IDX_W      = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_BUCKET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT      = 1'b1;

   localparam logic [SPB_W-1:0] SPB_RESET = 24'd1;
   localparam logic [NCH_W-1:0] NCH_RESET = 4'd2;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [NCH_W-1:0] nch;
   } stage_ctl_type;

endpackage

// ===== design/wmmd_req_if.sv =====
// Input channel of the decimator: one audio frame per word.
// Depends on nothing.
interface wmmd_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] chan0;
   logic signed [SAMPLE_BITS-1:0] chan1;
   logic signed [SAMPLE_BITS-1:0] chan2;
   logic signed [SAMPLE_BITS-1:0] chan3;
   logic signed [SAMPLE_BITS-1:0] chan4;
   logic signed [SAMPLE_BITS-1:0] chan5;
   logic signed [SAMPLE_BITS-1:0] chan6;
   logic signed [SAMPLE_BITS-1:0] chan7;
   logic                          last_frame;

   modport source (
      output valid, chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7, last_frame,
      input  ready
   );
   modport sink (
      input  valid, chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7, last_frame,
      output ready
   );
endinterface

// ===== design/wmmd_rsp_if.sv =====
// Result channel of the decimator: one bucket minimum and maximum per word.
// Depends on nothing.
interface wmmd_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] bucket_min;
   logic signed [SAMPLE_BITS-1:0] bucket_max;
   logic                          final_bucket;

   modport source (
      output valid, bucket_min, bucket_max, final_bucket,
      input  ready
   );
   modport sink (
      input  valid, bucket_min, bucket_max, final_bucket,
      output ready
   );
endinterface

// ===== design/wmmd_lane.sv =====
// One channel lane: registers its sample, or zero when the channel is inactive.
// Depends on wmmd_pkg.
module wmmd_lane #(
   parameter int SAMPLE_BITS = wmmd_pkg::SAMPLE_BITS,
   parameter int LANE        = 0
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [wmmd_pkg::NCH_W-1:0]    nch,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] lane_out
);
   logic                          active;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   assign active    = wmmd_pkg::NCH_W'(LANE) < nch;
   assign sample_in = active ? sample : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         sample_ff <= sample_in;
      end
   end

   assign lane_out = sample_ff;
endmodule

// ===== design/wmmd_merge.sv =====
// Merging stages: sums the lanes, then divides by the channel count through a
// reciprocal multiply and a one-step correction. Depends on wmmd_pkg.
module wmmd_merge #(
   parameter int MAX_CHANNELS = wmmd_pkg::MAX_CHANNELS,
   parameter int SAMPLE_BITS  = wmmd_pkg::SAMPLE_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  wmmd_pkg::stage_ctl_type                   ctl_in,
   input  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]  lanes,
   output wmmd_pkg::stage_ctl_type                   ctl_out,
   output logic signed [SAMPLE_BITS-1:0]             mean
);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS);
   localparam int K      = SUM_W;
   localparam int RW     = K + 1;
   localparam int PW     = SUM_W + RW;
   localparam int BW     = SUM_W + wmmd_pkg::NCH_W;
   localparam int TAB_N  = 2 ** wmmd_pkg::NCH_W;
   localparam logic [63:0] ONE_K = 64'd1 << K;

   logic [RW-1:0] recip_tab [TAB_N];

   for (genvar d = 0; d < TAB_N; d++) begin : g_recip
      localparam int DIV = (d == 0) ? 1 : d;
      localparam logic [63:0] ENTRY = ONE_K / DIV;
      assign recip_tab[d] = ENTRY[RW-1:0];
   end

   // Sum of the lanes and its magnitude.
   logic signed [SUM_W-1:0] sum_in;
   logic                    neg_in;
   logic [SUM_W-1:0]        mag_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         sum_in = SUM_W'(sum_in + SUM_W'($signed(lanes[i])));
      end
      neg_in = sum_in[SUM_W-1];
      mag_in = neg_in ? SUM_W'(~sum_in + 1'b1) : SUM_W'(sum_in);
   end

   wmmd_pkg::stage_ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic                    s1_neg_ff, s2_neg_ff;
   logic [SUM_W-1:0]        s1_mag_ff, s2_mag_ff, s2_q0_ff;
   logic signed [SAMPLE_BITS-1:0] mean_ff;

   // Estimated quotient, at most one below the true one.
   logic [PW-1:0]    prod_in;
   logic [SUM_W-1:0] q0_in;

   assign prod_in = PW'(s1_mag_ff) * PW'(recip_tab[s1_ctl_ff.nch]);
   assign q0_in   = prod_in[K +: SUM_W];

   // Correction and sign.
   logic [BW-1:0]           back_in;
   logic [SUM_W-1:0]        rem_in;
   logic                    bump_in;
   logic [SUM_W-1:0]        q_in;
   logic [SUM_W-1:0]        signed_q_in;
   logic signed [SAMPLE_BITS-1:0] mean_in;

   assign back_in     = BW'(s2_q0_ff) * BW'(s2_ctl_ff.nch);
   assign rem_in      = SUM_W'(BW'(s2_mag_ff) - back_in);
   assign bump_in     = rem_in >= SUM_W'(s2_ctl_ff.nch);
   assign q_in        = SUM_W'(s2_q0_ff + SUM_W'(bump_in));
   assign signed_q_in = s2_neg_ff ? SUM_W'(~q_in + 1'b1) : q_in;
   assign mean_in     = signed_q_in[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_neg_ff <= neg_in;
         s1_mag_ff <= mag_in;
         s2_neg_ff <= s1_neg_ff;
         s2_mag_ff <= s1_mag_ff;
         s2_q0_ff  <= q0_in;
         mean_ff   <= mean_in;
      end
   end

   assign ctl_out = s3_ctl_ff;
   assign mean    = mean_ff;
endmodule

// ===== design/wmmd_bucket.sv =====
// Bucket tracker: running minimum and maximum, frame count and the result
// register. Depends on wmmd_pkg and wmmd_rsp_if.
module wmmd_bucket #(
   parameter int SAMPLE_BITS = wmmd_pkg::SAMPLE_BITS,
   parameter int COUNT_BITS  = wmmd_pkg::COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wmmd_pkg::stage_ctl_type       ctl_in,
   input  logic signed [SAMPLE_BITS-1:0] mean,
   input  logic [wmmd_pkg::SPB_W-1:0]    spb,
   output logic                          en,
   wmmd_rsp_if.source                    rsp
);
   localparam int CMP_W = (COUNT_BITS > wmmd_pkg::SPB_W) ? COUNT_BITS : wmmd_pkg::SPB_W;
   localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [COUNT_BITS-1:0]         count_ff, count_in, count_inc;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, new_min;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in, new_max;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_max_ff;
   logic                          rsp_final_ff;
   logic [wmmd_pkg::SPB_W-1:0]    spb_eff;
   logic                          close;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign new_min   = (mean < min_ff) ? mean : min_ff;
   assign new_max   = (mean > max_ff) ? mean : max_ff;
   assign count_inc = (&count_ff) ? count_ff : COUNT_BITS'(count_ff + 1'b1);
   assign spb_eff   = (spb == '0) ? wmmd_pkg::SPB_W'(1) : spb;
   assign close     = (CMP_W'(count_inc) >= CMP_W'(spb_eff)) || ctl_in.last;

   always_comb begin
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         rsp_valid_in = ctl_in.valid && close;
         if (ctl_in.valid) begin
            if (close) begin
               count_in = '0;
               min_in   = MOST_POS;
               max_in   = MOST_NEG;
            end else begin
               count_in = count_inc;
               min_in   = new_min;
               max_in   = new_max;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= MOST_POS;
         max_ff       <= MOST_NEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && ctl_in.valid && close) begin
         rsp_min_ff   <= new_min;
         rsp_max_ff   <= new_max;
         rsp_final_ff <= ctl_in.last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.bucket_min   = rsp_min_ff;
   assign rsp.bucket_max   = rsp_max_ff;
   assign rsp.final_bucket = rsp_final_ff;
endmodule

// ===== design/waveform_minmax_decimator_core.sv =====
// Top level of the waveform min/max decimator: configuration registers,
// channel lanes, merge stages and bucket tracker.
// Depends on wmmd_pkg, wmmd_req_if, wmmd_rsp_if, wmmd_lane, wmmd_merge, wmmd_bucket.
//
//   port      direction  word
//   req       in         chan0..chan7, last_frame (one audio frame)
//   rsp       out        bucket_min, bucket_max, final_bucket
//   csr_*     in         write enable, register index, write data
//
// One frame is accepted per cycle while the pipeline is not held; the frame
// that closes a bucket passes through the lane register, sum, reciprocal
// multiply, correction and result register before its result leaves.
// The whole pipeline advances together and holds while a result waits in
// the result register and rsp.ready is low.
// Reset is synchronous and needs no clearing pass.
module waveform_minmax_decimator_core #(
   parameter int MAX_CHANNELS = wmmd_pkg::MAX_CHANNELS,
   parameter int SAMPLE_BITS  = wmmd_pkg::SAMPLE_BITS,
   parameter int COUNT_BITS   = wmmd_pkg::COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   wmmd_req_if.sink                           req,
   wmmd_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [wmmd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wmmd_pkg::CSR_W-1:0]         csr_wdata
);
   logic [wmmd_pkg::SPB_W-1:0] spb_ff, spb_in;
   logic [wmmd_pkg::NCH_W-1:0] nch_ff, nch_in, nch_eff;
   logic                       en;

   always_comb begin
      spb_in = spb_ff;
      nch_in = nch_ff;
      if (csr_we) begin
         case (csr_index)
            wmmd_pkg::CSR_SAMPLES_PER_BUCKET: begin
               spb_in = csr_wdata[wmmd_pkg::SPB_W-1:0];
            end
            wmmd_pkg::CSR_CHANNEL_COUNT: begin
               nch_in = csr_wdata[wmmd_pkg::NCH_W-1:0];
            end
            default: begin
               spb_in = spb_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= wmmd_pkg::SPB_RESET;
         nch_ff <= wmmd_pkg::NCH_RESET;
      end else begin
         spb_ff <= spb_in;
         nch_ff <= nch_in;
      end
   end

   always_comb begin
      if (nch_ff == '0) begin
         nch_eff = wmmd_pkg::NCH_W'(1);
      end else if (nch_ff > wmmd_pkg::NCH_W'(MAX_CHANNELS)) begin
         nch_eff = wmmd_pkg::NCH_W'(MAX_CHANNELS);
      end else begin
         nch_eff = nch_ff;
      end
   end

   assign req.ready = en;

   wmmd_pkg::stage_ctl_type s0_ctl_ff, s0_ctl_in;

   assign s0_ctl_in = '{valid: req.valid, last: req.last_frame, nch: nch_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else if (en) begin
         s0_ctl_ff <= s0_ctl_in;
      end
   end

   logic [wmmd_pkg::FIELD_CHANNELS-1:0][SAMPLE_BITS-1:0] chan_all;
   logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]             lanes;

   assign chan_all[0] = req.chan0;
   assign chan_all[1] = req.chan1;
   assign chan_all[2] = req.chan2;
   assign chan_all[3] = req.chan3;
   assign chan_all[4] = req.chan4;
   assign chan_all[5] = req.chan5;
   assign chan_all[6] = req.chan6;
   assign chan_all[7] = req.chan7;

   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      wmmd_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .LANE        (g)
      ) u_lane (
         .clock    (clock),
         .en       (en),
         .nch      (nch_eff),
         .sample   (chan_all[g]),
         .lane_out (lanes[g])
      );
   end

   wmmd_pkg::stage_ctl_type       merge_ctl;
   logic signed [SAMPLE_BITS-1:0] mean;

   wmmd_merge #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (s0_ctl_ff),
      .lanes   (lanes),
      .ctl_out (merge_ctl),
      .mean    (mean)
   );

   wmmd_bucket #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_bucket (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (merge_ctl),
      .mean   (mean),
      .spb    (spb_ff),
      .en     (en),
      .rsp    (rsp)
   );
endmodule
